// ===== rtl/core/pgn_pkg.sv =====
// ---------------------------------------------------------------------------
// pgn_pkg
// Shared types, codes and helpers of the gradient noise unit.
// ---------------------------------------------------------------------------
package pgn_pkg;

  // item opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_EVAL3 = 2'd1;
  localparam logic [1:0] OP_FBM   = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST = 2'd1;

  localparam int          MAX_OCTAVES_DEF = 8;
  localparam logic [3:0]  OCT_RESET       = 4'd6;
  localparam logic [15:0] PERS_RESET      = 16'd32768;

  localparam int MUL_W  = 25;  // signed operand width of the shared multiplier
  localparam int GRAD_W = 19;  // gradient dot product
  localparam int LV_W   = 20;  // interpolated values, Q16
  localparam int STEP_W = 6;   // sequencer step, covers the division iterations

  localparam logic [STEP_W-1:0] HASH_LAST = 6'd14;
  localparam logic [STEP_W-1:0] FADE_LAST = 6'd4;
  localparam logic [STEP_W-1:0] LERP_LAST = 6'd1;
  localparam logic [STEP_W-1:0] ACC_LAST  = 6'd2;
  localparam logic [2:0]        AXIS_LAST = 3'd2;
  localparam logic [2:0]        LERP_IDX_LAST = 3'd6;

  typedef struct packed {
    logic              load;
    logic              launch;
    logic              fbm;
    logic              hash;
    logic              fade;
    logic              lerp;
    logic              acc;
    logic              div;
    logic              fin;
    logic [STEP_W-1:0] step;
    logic [2:0]        sel;
  } pgn_cmd_t;

  typedef struct packed {
    logic last_oct;
  } pgn_status_t;

  // improved noise gradient: +-u +-v picked by the low four hash bits
  function automatic logic signed [GRAD_W-1:0] pgn_grad(
    input logic [3:0]         h,
    input logic signed [17:0] gx,
    input logic signed [17:0] gy,
    input logic signed [17:0] gz
  );
    logic signed [GRAD_W-1:0] u;
    logic signed [GRAD_W-1:0] v;
    u = (h < 4'd8) ? GRAD_W'(gx) : GRAD_W'(gy);
    if (h < 4'd4) begin
      v = GRAD_W'(gy);
    end else if (h == 4'd12 || h == 4'd14) begin
      v = GRAD_W'(gx);
    end else begin
      v = GRAD_W'(gz);
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

// ===== rtl/core/pgn_ctrl.sv =====
// ---------------------------------------------------------------------------
// pgn_ctrl
// Sequencer: steps the datapath through hashing, fade, interpolation,
// octave accumulation and the normalizing division.
// ---------------------------------------------------------------------------
module pgn_ctrl
  import pgn_pkg::*;
#(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  in_opcode,
  input  pgn_status_t status,
  output logic        busy,
  output pgn_cmd_t    cmd
);

  localparam int TOT_W = 36 + $clog2(MAX_OCTAVES);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(TOT_W - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_HASH = 7'b0000010,
    S_FADE = 7'b0000100,
    S_LERP = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [2:0]        sel_r, sel_nxt;
  logic              mode_r, mode_nxt;
  logic              is_eval;

  assign busy    = (state_r != S_IDLE);
  assign is_eval = (in_opcode == OP_EVAL3) || (in_opcode == OP_FBM);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    sel_nxt   = sel_r;
    mode_nxt  = mode_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && is_eval) begin
          state_nxt = S_HASH;
          step_nxt  = '0;
          sel_nxt   = '0;
          mode_nxt  = (in_opcode == OP_FBM);
        end
      end
      S_HASH: begin
        if (step_r == HASH_LAST) begin
          state_nxt = S_FADE;
          step_nxt  = '0;
          sel_nxt   = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_FADE: begin
        if (step_r == FADE_LAST) begin
          step_nxt = '0;
          if (sel_r == AXIS_LAST) begin
            state_nxt = S_LERP;
            sel_nxt   = '0;
          end else begin
            sel_nxt = sel_r + 1'b1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_LERP: begin
        if (step_r == LERP_LAST) begin
          step_nxt = '0;
          if (sel_r == LERP_IDX_LAST) begin
            state_nxt = mode_r ? S_ACC : S_FIN;
            sel_nxt   = '0;
          end else begin
            sel_nxt = sel_r + 1'b1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_ACC: begin
        if (step_r == ACC_LAST) begin
          step_nxt  = '0;
          state_nxt = status.last_oct ? S_DIV : S_HASH;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DIV: begin
        if (step_r == DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      sel_r   <= '0;
      mode_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      sel_r   <= sel_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_comb begin
    cmd.load   = (state_r == S_IDLE) && start && (in_opcode == OP_LOAD);
    cmd.launch = (state_r == S_IDLE) && start && is_eval;
    cmd.fbm    = cmd.launch ? (in_opcode == OP_FBM) : mode_r;
    cmd.hash   = (state_r == S_HASH);
    cmd.fade   = (state_r == S_FADE);
    cmd.lerp   = (state_r == S_LERP);
    cmd.acc    = (state_r == S_ACC);
    cmd.div    = (state_r == S_DIV);
    cmd.fin    = (state_r == S_FIN);
    cmd.step   = step_r;
    cmd.sel    = sel_r;
  end

`ifndef ASSERT_OFF
  a_div_only_fbm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> mode_r)
    else $error("division entered for a 3d evaluation");

  a_fin_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> (state_r == S_IDLE))
    else $error("finish did not return to idle");

  a_launch_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_opcode == OP_EVAL3 || in_opcode == OP_FBM))
      |=> (state_r == S_HASH))
    else $error("accepted evaluation did not start hashing");
`endif

endmodule

// ===== rtl/core/pgn_dp.sv =====
// ---------------------------------------------------------------------------
// pgn_dp
// Datapath: permutation memory, shared multiplier, fade and interpolation
// registers, octave accumulators and a restoring divider.
// ---------------------------------------------------------------------------
module pgn_dp
  import pgn_pkg::*;
#(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pgn_cmd_t             cmd,
  output pgn_status_t          status,
  input  logic [7:0]           in_table_index,
  input  logic [7:0]           in_table_value,
  input  logic signed [31:0]   in_x_coord,
  input  logic signed [31:0]   in_y_coord,
  input  logic signed [31:0]   in_z_coord,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 out_valid,
  output logic signed [15:0]   out_noise_value
);

  localparam int TOT_W = 36 + $clog2(MAX_OCTAVES);
  localparam int WGT_W = 17 + $clog2(MAX_OCTAVES);
  localparam int OCT_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int PW    = 2 * MUL_W;
  localparam logic [4:0] MAXN = 5'(MAX_OCTAVES);
  localparam logic signed [PW-1:0] P_BIAS = PW'(10) << 32;
  localparam logic signed [TOT_W:0] Q_MAX = (TOT_W+1)'(32767);
  localparam logic signed [TOT_W:0] Q_MIN = -(TOT_W+1)'(32768);

  // configuration
  logic [3:0]  oct_cfg_r;
  logic [15:0] pers_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cfg_r <= OCT_RESET;
      pers_r    <= PERS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_OCTAVES) begin
        oct_cfg_r <= cfg_data[3:0];
      end else if (cfg_index == REG_PERSIST) begin
        pers_r <= cfg_data;
      end
    end
  end

  logic [4:0] n_eff;
  always_comb begin
    if (oct_cfg_r == 4'd0) begin
      n_eff = 5'd1;
    end else if ({1'b0, oct_cfg_r} > MAXN) begin
      n_eff = MAXN;
    end else begin
      n_eff = {1'b0, oct_cfg_r};
    end
  end

  // permutation memory
  logic [7:0] perm_mem [256];
  logic [7:0] rd_addr;
  logic [7:0] rd_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      perm_mem[in_table_index] <= in_table_value;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= perm_mem[rd_addr];
  end

  // coordinates and hash registers
  logic [31:0] x_r, y_r, z_r;
  logic [7:0]  a_r, b_r, aa_r, ab_r, ba_r, bb_r;
  logic [7:0]  hash_r [8];
  logic [OCT_W-1:0] oct_r;

  assign status.last_oct = ((5'(oct_r) + 5'd1) == n_eff);

  always_comb begin
    case (cmd.step)
      6'd0:    rd_addr = x_r[23:16];
      6'd1:    rd_addr = x_r[23:16] + 8'd1;
      6'd2:    rd_addr = a_r;
      6'd3:    rd_addr = a_r + 8'd1;
      6'd4:    rd_addr = b_r;
      6'd5:    rd_addr = b_r + 8'd1;
      6'd6:    rd_addr = aa_r;
      6'd7:    rd_addr = aa_r + 8'd1;
      6'd8:    rd_addr = ba_r;
      6'd9:    rd_addr = ba_r + 8'd1;
      6'd10:   rd_addr = ab_r;
      6'd11:   rd_addr = ab_r + 8'd1;
      6'd12:   rd_addr = bb_r;
      6'd13:   rd_addr = bb_r + 8'd1;
      default: rd_addr = x_r[23:16];
    endcase
  end

  // read data is registered and arrives in the step after its address
  always_ff @(posedge clk) begin
    if (cmd.hash) begin
      case (cmd.step)
        6'd1:  a_r       <= rd_r + y_r[23:16];
        6'd2:  b_r       <= rd_r + y_r[23:16];
        6'd3:  aa_r      <= rd_r + z_r[23:16];
        6'd4:  ab_r      <= rd_r + z_r[23:16];
        6'd5:  ba_r      <= rd_r + z_r[23:16];
        6'd6:  bb_r      <= rd_r + z_r[23:16];
        6'd7:  hash_r[0] <= rd_r;
        6'd8:  hash_r[4] <= rd_r;
        6'd9:  hash_r[1] <= rd_r;
        6'd10: hash_r[5] <= rd_r;
        6'd11: hash_r[2] <= rd_r;
        6'd12: hash_r[6] <= rd_r;
        6'd13: hash_r[3] <= rd_r;
        6'd14: hash_r[7] <= rd_r;
        default: ;
      endcase
    end
  end

  // gradients at the eight corners; corner bit 0/1/2 selects x-1/y-1/z-1
  logic signed [17:0]       fx, fy, fz, fx1, fy1, fz1;
  logic signed [GRAD_W-1:0] grad [8];

  assign fx  = $signed({2'b00, x_r[15:0]});
  assign fy  = $signed({2'b00, y_r[15:0]});
  assign fz  = $signed({2'b00, z_r[15:0]});
  assign fx1 = fx - 18'sd65536;
  assign fy1 = fy - 18'sd65536;
  assign fz1 = fz - 18'sd65536;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      grad[i] = pgn_grad(hash_r[i][3:0],
                         ((i & 1) != 0) ? fx1 : fx,
                         ((i & 2) != 0) ? fy1 : fy,
                         ((i & 4) != 0) ? fz1 : fz);
    end
  end

  // shared multiplier
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PW-1:0]    mp_r;

  always_ff @(posedge clk) begin
    mp_r <= mul_a * mul_b;
  end

  // fade
  logic [15:0]        t_sel;
  logic signed [21:0] six_t;
  logic signed [PW-1:0] p_full;
  logic [15:0]        t2_r;
  logic [19:0]        p_r;
  logic [16:0]        fade_r [3];

  always_comb begin
    case (cmd.sel[1:0])
      2'd0:    t_sel = x_r[15:0];
      2'd1:    t_sel = y_r[15:0];
      default: t_sel = z_r[15:0];
    endcase
  end

  assign six_t  = $signed(22'(t_sel) * 22'd6 - 22'd983040);
  assign p_full = mp_r + P_BIAS;

  // interpolation
  logic [16:0]             lt;
  logic signed [LV_W-1:0]  la, lb;
  logic signed [LV_W:0]    ldiff;
  logic signed [LV_W-1:0]  lv_r [7];

  always_comb begin
    case (cmd.sel)
      3'd0: begin
        lt = fade_r[0]; la = LV_W'(grad[0]); lb = LV_W'(grad[1]);
      end
      3'd1: begin
        lt = fade_r[0]; la = LV_W'(grad[2]); lb = LV_W'(grad[3]);
      end
      3'd2: begin
        lt = fade_r[0]; la = LV_W'(grad[4]); lb = LV_W'(grad[5]);
      end
      3'd3: begin
        lt = fade_r[0]; la = LV_W'(grad[6]); lb = LV_W'(grad[7]);
      end
      3'd4: begin
        lt = fade_r[1]; la = lv_r[0]; lb = lv_r[1];
      end
      3'd5: begin
        lt = fade_r[1]; la = lv_r[2]; lb = lv_r[3];
      end
      default: begin
        lt = fade_r[2]; la = lv_r[4]; lb = lv_r[5];
      end
    endcase
  end

  assign ldiff = (LV_W+1)'(lb) - (LV_W+1)'(la);

  // octave accumulation and division
  logic [16:0]             amp_r;
  logic signed [TOT_W-1:0] total_r;
  logic [WGT_W-1:0]        weight_r;
  logic [TOT_W-1:0]        quo_r;
  logic [WGT_W-1:0]        rem_r;
  logic                    neg_r;
  logic [WGT_W:0]          rem_sh;
  logic [WGT_W:0]          rem_sub;

  assign rem_sh  = {rem_r, quo_r[TOT_W-1]};
  assign rem_sub = rem_sh - {1'b0, weight_r};

  always_comb begin
    mul_a = MUL_W'($signed({1'b0, t_sel}));
    mul_b = MUL_W'($signed({1'b0, t_sel}));
    if (cmd.fade) begin
      case (cmd.step)
        6'd1: begin
          mul_b = MUL_W'(six_t);
        end
        6'd2: begin
          mul_a = MUL_W'($signed({1'b0, t2_r}));
        end
        6'd3: begin
          mul_a = MUL_W'($signed({1'b0, mp_r[31:16]}));
          mul_b = MUL_W'($signed({1'b0, p_r}));
        end
        default: ;
      endcase
    end else if (cmd.lerp) begin
      mul_a = MUL_W'($signed({1'b0, lt}));
      mul_b = MUL_W'(ldiff);
    end else if (cmd.acc) begin
      if (cmd.step == 6'd0) begin
        mul_a = MUL_W'(lv_r[6]);
        mul_b = MUL_W'($signed({1'b0, amp_r}));
      end else begin
        mul_a = MUL_W'($signed({1'b0, amp_r}));
        mul_b = MUL_W'($signed({1'b0, pers_r}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.launch) begin
      x_r      <= in_x_coord;
      y_r      <= in_y_coord;
      z_r      <= cmd.fbm ? 32'd0 : in_z_coord;
      total_r  <= '0;
      weight_r <= '0;
      amp_r    <= 17'd65536;
      oct_r    <= '0;
    end
    if (cmd.fade) begin
      case (cmd.step)
        6'd1:    t2_r <= mp_r[31:16];
        6'd2:    p_r  <= p_full[35:16];
        6'd4:    fade_r[cmd.sel[1:0]] <= mp_r[32:16];
        default: ;
      endcase
    end
    if (cmd.lerp && cmd.step == LERP_LAST) begin
      lv_r[cmd.sel] <= la + LV_W'(mp_r >>> 16);
    end
    if (cmd.acc) begin
      case (cmd.step)
        6'd1: begin
          total_r  <= total_r + TOT_W'(mp_r);
          weight_r <= weight_r + WGT_W'(amp_r);
        end
        6'd2: begin
          amp_r <= mp_r[32:16];
          x_r   <= {x_r[30:0], 1'b0};
          y_r   <= {y_r[30:0], 1'b0};
          oct_r <= oct_r + 1'b1;
          // divider setup, used only after the last octave
          neg_r <= total_r[TOT_W-1];
          quo_r <= total_r[TOT_W-1] ? TOT_W'(-total_r) : TOT_W'(total_r);
          rem_r <= '0;
        end
        default: ;
      endcase
    end
    if (cmd.div) begin
      if (rem_sh >= {1'b0, weight_r}) begin
        rem_r <= rem_sub[WGT_W-1:0];
        quo_r <= {quo_r[TOT_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[WGT_W-1:0];
        quo_r <= {quo_r[TOT_W-2:0], 1'b0};
      end
    end
  end

  // output truncation and saturation
  logic signed [TOT_W:0] res_full;
  logic signed [TOT_W:0] res_half;
  logic signed [15:0]    res_sat;

  always_comb begin
    if (cmd.fbm) begin
      res_full = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    end else begin
      res_full = (TOT_W+1)'(lv_r[6]);
    end
    res_half = res_full >>> 1;
    if (res_half > Q_MAX) begin
      res_sat = 16'sh7fff;
    end else if (res_half < Q_MIN) begin
      res_sat = -16'sh8000;
    end else begin
      res_sat = res_half[15:0];
    end
  end

  logic               out_valid_r;
  logic signed [15:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_value_r <= res_sat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_value_r;

`ifndef ASSERT_OFF
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_weight_floor: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |-> (weight_r >= WGT_W'(65536)))
    else $error("divisor below one during division");

  a_amp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |-> (amp_r <= 17'd65536))
    else $error("octave amplitude above one");
`endif

endmodule

// ===== rtl/core/perlin_gradient_noise_fbm_unit.sv =====
// ---------------------------------------------------------------------------
// perlin_gradient_noise_fbm_unit
// Improved gradient noise, 3d samples and fractal 2d sums, Q1.15 output.
// ---------------------------------------------------------------------------
// Items are taken when start is high and busy is low. A load item writes one
// permutation entry in the cycle it is accepted and keeps busy low. An
// evaluation holds busy through table lookups (one memory read per cycle),
// fade and interpolation on the single shared multiplier, after which a 3d
// sample is strobed on out_valid. A fractal item runs these steps and an
// accumulation for each octave, then a one bit per cycle divide over
// 36 + clog2(MAX_OCTAVES) quotient bits (39 by default); the octave count is
// six after reset. Each result appears for one cycle on out_valid, and
// out_noise_value keeps it until the next; a new item may be given then.
// Configuration writes are always ready and are meant for idle periods.
module perlin_gradient_noise_fbm_unit
  import pgn_pkg::*;
#(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_opcode,
  input  logic [7:0]           in_table_index,
  input  logic [7:0]           in_table_value,
  input  logic signed [31:0]   in_x_coord,
  input  logic signed [31:0]   in_y_coord,
  input  logic signed [31:0]   in_z_coord,
  output logic                 out_valid,
  output logic signed [15:0]   out_noise_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  pgn_cmd_t    cmd;
  pgn_status_t status;

  assign cfg_ready = 1'b1;

  pgn_ctrl #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  pgn_dp #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_table_index  (in_table_index),
    .in_table_value  (in_table_value),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_z_coord      (in_z_coord),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_noise_value (out_noise_value)
  );

endmodule

// ===== dv/noise_checker.sv =====
// ---------------------------------------------------------------------------
// noise_checker
// Watches the item, result and register channels of the gradient noise unit,
// keeps its own copy of the permutation table and registers, predicts each
// noise sample in fixed point and compares it with the strobed result.
// ---------------------------------------------------------------------------
module noise_checker
  import pgn_pkg::*;
#(
  parameter int MAX_OCT = MAX_OCTAVES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           in_opcode,
  input  logic [7:0]           in_table_index,
  input  logic [7:0]           in_table_value,
  input  logic signed [31:0]   in_x_coord,
  input  logic signed [31:0]   in_y_coord,
  input  logic signed [31:0]   in_z_coord,
  input  logic                 out_valid,
  input  logic signed [15:0]   out_noise_value,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]        perm_copy [256];
  logic [3:0]        octaves;
  logic [15:0]       persist;
  logic signed [15:0] samples_due [$];

  assign pending = samples_due.size();

  function automatic longint fade_curve(longint t);
    longint t2, t3, p;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    p  = (t * (6 * t - 15 * 65536) + 10 * (longint'(1) << 32)) >>> 16;
    return (t3 * p) >>> 16;
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + ((t * (b - a)) >>> 16);
  endfunction

  function automatic longint grad_dot(logic [7:0] hv, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hv[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] perm(int i);
    return perm_copy[i & 255];
  endfunction

  function automatic longint sample_q16(logic [31:0] xs, logic [31:0] ys, logic [31:0] zs);
    int cx, cy, cz, a, aa, ab, b, ba, bb;
    longint x, y, z, u, v, w, one, near_z, far_z;
    cx = xs[23:16]; cy = ys[23:16]; cz = zs[23:16];
    x = xs[15:0]; y = ys[15:0]; z = zs[15:0];
    u = fade_curve(x); v = fade_curve(y); w = fade_curve(z);
    one = 65536;
    a = perm(cx) + cy; aa = perm(a) + cz; ab = perm(a + 1) + cz;
    b = perm(cx + 1) + cy; ba = perm(b) + cz; bb = perm(b + 1) + cz;
    near_z = blend(v,
      blend(u, grad_dot(perm(aa), x, y, z), grad_dot(perm(ba), x - one, y, z)),
      blend(u, grad_dot(perm(ab), x, y - one, z), grad_dot(perm(bb), x - one, y - one, z)));
    far_z = blend(v,
      blend(u, grad_dot(perm(aa + 1), x, y, z - one),
               grad_dot(perm(ba + 1), x - one, y, z - one)),
      blend(u, grad_dot(perm(ab + 1), x, y - one, z - one),
               grad_dot(perm(bb + 1), x - one, y - one, z - one)));
    return blend(w, near_z, far_z);
  endfunction

  function automatic logic signed [15:0] to_q15(longint q16);
    longint r;
    r = q16 >>> 1;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic logic signed [15:0] fractal_sum(logic [31:0] xs, logic [31:0] ys);
    int n;
    longint total, weight, amp;
    n = octaves;
    total = 0; weight = 0; amp = 65536;
    if (n < 1) n = 1;
    if (n > MAX_OCT) n = MAX_OCT;
    for (int i = 0; i < n; i++) begin
      total += sample_q16(xs << i, ys << i, 32'd0) * amp;
      weight += amp;
      amp = (amp * longint'(persist)) >>> 16;
    end
    return to_q15(total / weight);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      octaves <= OCT_RESET;
      persist <= PERS_RESET;
      errors  <= 0;
      samples_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_OCTAVES) octaves <= cfg_data[3:0];
        else if (cfg_index == REG_PERSIST) persist <= cfg_data;
      end
      if (start && !busy) begin
        case (in_opcode)
          OP_LOAD:  perm_copy[in_table_index] <= in_table_value;
          OP_EVAL3: samples_due.push_back(to_q15(sample_q16(in_x_coord, in_y_coord,
                                                            in_z_coord)));
          OP_FBM:   samples_due.push_back(fractal_sum(in_x_coord, in_y_coord));
          default: ;
        endcase
      end
      if (out_valid) begin
        if (samples_due.size() == 0) begin
          if (errors < 10) $display("unexpected result %0d", out_noise_value);
          errors <= errors + 1;
        end else begin
          if (samples_due[0] !== out_noise_value) begin
            if (errors < 10)
              $display("noise mismatch: expected %0d actual %0d", samples_due[0],
                       out_noise_value);
            errors <= errors + 1;
          end
          void'(samples_due.pop_front());
        end
      end
    end
  end
endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Stimulus for the gradient noise unit: fills the permutation table, runs
// directed corner samples and fractal items, then random item phases under
// several register settings and random idle gaps, checked by noise_checker.
// ---------------------------------------------------------------------------
module testbench;
  import pgn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]           OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd2;
  localparam int                   CYCLE_CAP  = 3000000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_opcode = OP_LOAD;
  logic [7:0]           in_table_index = '0;
  logic [7:0]           in_table_value = '0;
  logic signed [31:0]   in_x_coord = '0;
  logic signed [31:0]   in_y_coord = '0;
  logic signed [31:0]   in_z_coord = '0;
  logic                 out_valid;
  logic signed [15:0]   out_noise_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  int                   errors;
  int                   pending;
  int                   cycles = 0;

  always #2 clk = ~clk;

  perlin_gradient_noise_fbm_unit uut (.*);
  noise_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 120);
  endfunction

  task automatic send(logic [1:0] op, logic [7:0] idx, logic [7:0] val,
                      logic [31:0] x, logic [31:0] y, logic [31:0] z, int gap);
    bit taken;
    start <= 1'b1;
    in_opcode <= op; in_table_index <= idx; in_table_value <= val;
    in_x_coord <= x; in_y_coord <= y; in_z_coord <= z;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // registers only change once the unit has drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    bit taken;
    if (start) start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {16'($urandom_range(0, 3) - 2), 16'($urandom)};
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] corners [6];
    int r;
    corners = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0000ffff, 32'h00ff8000};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // every entry written before any sample reads the table
    for (int i = 0; i < 256; i++)
      send(OP_LOAD, 8'(i), 8'($urandom), '0, '0, '0, (i % 37 == 0) ? pick_gap() : 0);
    for (int i = 0; i < 6; i++)
      send(OP_EVAL3, 8'hff, 8'hff, corners[i], corners[(i + 1) % 6], corners[(i + 3) % 6],
           pick_gap());
    send(OP_UNUSED, 8'hff, 8'hff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
    send(OP_FBM, '0, '0, 32'h7fffffff, 32'h80000000, 32'h12345678, 0);
    send(OP_FBM, '0, '0, 32'h00018000, 32'hfffe4000, '0, 1);
    write_reg(REG_OCTAVES, 16'd8);
    write_reg(REG_PERSIST, 16'hffff);
    send(OP_FBM, '0, '0, 32'hffffffff, 32'h0000ffff, '0, 0);
    write_reg(REG_OCTAVES, 16'd0);
    write_reg(REG_PERSIST, 16'd0);
    send(OP_FBM, '0, '0, 32'h00ff8000, 32'h80000000, '0, 0);
    write_reg(REG_OCTAVES, 16'd15);
    write_reg(REG_SPARE, 16'hffff);
    send(OP_FBM, '0, '0, 32'h7fffffff, 32'h7fffffff, '0, 2);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: write_reg(REG_OCTAVES, 16'd1);
        1: write_reg(REG_OCTAVES, 16'd8);
        2: write_reg(REG_OCTAVES, 16'(4'($urandom)) | 16'(($urandom & 3) << 14));
        default: write_reg(REG_OCTAVES, 16'($urandom_range(1, 5)));
      endcase
      case (ph % 4)
        0: write_reg(REG_PERSIST, 16'hffff);
        1: write_reg(REG_PERSIST, 16'd0);
        default: write_reg(REG_PERSIST, 16'($urandom));
      endcase
      for (int k = 0; k < 165; k++) begin
        r = $urandom_range(0, 99);
        if (r < 55)
          send(OP_EVAL3, 8'($urandom), 8'($urandom), rand_coord(), rand_coord(),
               rand_coord(), (k % 40 < 8) ? 0 : pick_gap());
        else if (r < 82)
          send(OP_FBM, 8'($urandom), 8'($urandom), rand_coord(), rand_coord(),
               rand_coord(), (k % 40 < 8) ? 0 : pick_gap());
        else if (r < 95)
          send(OP_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom,
               pick_gap());
        else
          send(OP_UNUSED, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom,
               pick_gap());
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (500) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
